// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the joint controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, off while reset is asserted
`define MMJC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define MMJC_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMJC_ASSERT(name, prop, msg)
`define MMJC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== design/mmjc_pkg.sv =====
// Types, codes and saturation helpers of the joint controller.
package mmjc_pkg;

	// operand and accumulator widths of the shared gain multiplier
	localparam int GAIN_W  = 32;
	localparam int X_W     = 49;
	localparam int PROD_W  = 58;
	localparam int ACC_W   = 81;
	localparam int TERM_W  = 62;
	localparam int INTEG_W = 48;
	localparam int SUM_W   = 64;
	localparam int LO_W    = 24;

	typedef logic signed [X_W-1:0]     x_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [INTEG_W-1:0] integ_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	// control modes; any other code is position control
	localparam logic [2:0] MODE_TORQUE = 3'd1;
	localparam logic [2:0] MODE_OPEN   = 3'd2;
	localparam logic [2:0] MODE_IMPED  = 3'd3;

	// configuration register indexes
	localparam logic [2:0] REG_KP_POS = 3'd0;
	localparam logic [2:0] REG_KD_POS = 3'd1;
	localparam logic [2:0] REG_KI_POS = 3'd2;
	localparam logic [2:0] REG_KP_TQ  = 3'd3;
	localparam logic [2:0] REG_STIFF  = 3'd4;
	localparam logic [2:0] REG_DAMP   = 3'd5;
	localparam logic [2:0] REG_VLIM   = 3'd6;

	localparam logic [30:0] VLIM_RESET = 31'd1572864;

	// floor(g*x/2^16) limited to +/- 2^60
	function automatic term_t sat_term(input acc_t acc);
		logic signed [64:0] sh;
		logic signed [64:0] cap;
		sh  = acc[ACC_W-1:16];
		cap = 65'sh1000000000000000;
		if (sh > cap)
			sat_term = TERM_W'(cap);
		else if (sh < -cap)
			sat_term = TERM_W'(-cap);
		else
			sat_term = sh[TERM_W-1:0];
	endfunction

	// integrator range [-2^47, 2^47-1]
	function automatic integ_t sat_integ(input logic signed [62:0] s);
		logic signed [62:0] hi;
		logic signed [62:0] lo;
		hi = 63'sh7FFFFFFFFFFF;
		lo = -63'sh800000000000;
		if (s > hi)
			sat_integ = integ_t'(hi);
		else if (s < lo)
			sat_integ = integ_t'(lo);
		else
			sat_integ = s[INTEG_W-1:0];
	endfunction

	// signed 32-bit range
	function automatic logic signed [31:0] sat32(input sum_t s);
		if (s > 64'sd2147483647)
			sat32 = 32'sh7FFFFFFF;
		else if (s < -64'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = s[31:0];
	endfunction

endpackage

// ===== design/mmjc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mmjc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
	output logic [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	// registered read port, holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/multi_mode_joint_controller_unit.sv =====
// Multi-mode joint controller: one joint sample in, one clamped drive voltage out.
// Each word on the input names a joint and a mode and carries references and
// measurements; the answer is the voltage clamped to +/- voltage_limit, a clamp
// flag and the torque reference used. All gain products go through one shared
// 33x25 signed multiplier that forms each product in two halves; each product
// passes through operand setup, two multiply passes, accumulate, saturate and
// combine. An item needs four products in position mode (one of them updating
// the per-joint integrator), three in impedance mode, one in torque mode and
// none in open loop. in_stall is high while an item is in work; a finished
// word waits in the output register and does not hold up the next accept. The
// integrators sit in a small RAM with one valid bit per entry, so reset clears
// them at once.
`include "assert_macros.svh"

module multi_mode_joint_controller_unit
	import mmjc_pkg::*;
#(
	parameter int NUM_JOINTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         joint_index,
	input  logic [2:0]         mode,
	input  logic signed [31:0] position_ref,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity,
	input  logic signed [31:0] torque_ref,
	input  logic signed [31:0] torque_measured,
	input  logic [30:0]        time_step,
	input  logic signed [31:0] direct_voltage,
	// result output
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         joint_out,
	output logic signed [31:0] voltage,
	output logic               clamped,
	output logic signed [31:0] torque_ref_used,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int AW = $clog2(NUM_JOINTS > 1 ? NUM_JOINTS : 2);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_POST  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	// gain products
	localparam logic [2:0] OP_INT = 3'd0;  // time_step * error
	localparam logic [2:0] OP_KP  = 3'd1;  // kp * error
	localparam logic [2:0] OP_KD  = 3'd2;  // kd * velocity
	localparam logic [2:0] OP_KI  = 3'd3;  // ki * integral
	localparam logic [2:0] OP_STF = 3'd4;  // stiffness * error
	localparam logic [2:0] OP_DMP = 3'd5;  // damping * velocity
	localparam logic [2:0] OP_TQ  = 3'd6;  // kp_torque * torque error

	localparam logic [1:0] PH_LAST = 2'd3;

	// configuration registers
	logic [31:0] kp_pos_q, kd_pos_q, ki_pos_q, kp_tq_q, stiff_q, damp_q;
	logic [30:0] vlim_q;

	// sequencer
	logic [2:0]  st_q;
	logic [2:0]  op_q;
	logic [1:0]  ph_q;

	// captured item
	logic [4:0]          joint_q;
	logic                in_range_q;
	logic signed [32:0]  err_q;
	logic signed [31:0]  vel_q;
	logic signed [31:0]  tref_q;
	logic signed [31:0]  tmeas_q;
	logic [30:0]         ts_q;

	// shared multiplier datapath
	logic [GAIN_W-1:0]   g_q;
	x_t                  x_q;
	prod_t               prod_q;
	acc_t                acc_q;
	term_t               term_q;
	integ_t              integ_q;
	sum_t                vsum_q;

	// output register
	logic                out_valid_q;
	logic [4:0]          joint_out_q;
	logic signed [31:0]  voltage_q;
	logic                clamped_q;
	logic signed [31:0]  tref_out_q;

	// integrator store
	logic [NUM_JOINTS-1:0] vld_q;
	logic [AW-1:0]         addr_q;
	logic                  ram_we;
	logic [INTEG_W-1:0]    ram_rd;
	integ_t                integ_base;
	integ_t                integ_next;

	logic                  accept;
	logic signed [32:0]    mul_a;
	logic signed [24:0]    mul_b;
	prod_t                 mul_p;
	logic signed [32:0]    tdiff;
	sum_t                  lim;
	sum_t                  v_clamp;
	logic                  v_flag;
	logic                  out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_pos_q <= '0;
			kd_pos_q <= '0;
			ki_pos_q <= '0;
			kp_tq_q  <= '0;
			stiff_q  <= '0;
			damp_q   <= '0;
			vlim_q   <= VLIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KP_POS: kp_pos_q <= cfg_data;
				REG_KD_POS: kd_pos_q <= cfg_data;
				REG_KI_POS: ki_pos_q <= cfg_data;
				REG_KP_TQ:  kp_tq_q  <= cfg_data;
				REG_STIFF:  stiff_q  <= cfg_data;
				REG_DAMP:   damp_q   <= cfg_data;
				REG_VLIM:   vlim_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// integrator RAM, read at accept, written after the integral step
	mmjc_ram #(
		.WIDTH (INTEG_W),
		.DEPTH (NUM_JOINTS)
	) u_integ_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (addr_q),
		.wr_data (integ_next),
		.rd_en   (accept),
		.rd_addr (AW'(joint_index)),
		.rd_data (ram_rd)
	);

	// an entry never written since reset reads as zero
	assign integ_base = vld_q[addr_q] ? $signed(ram_rd) : '0;
	assign integ_next = sat_integ(63'(integ_base) + 63'(term_q));
	assign ram_we     = (st_q == ST_POST) && (op_q == OP_INT) && in_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (ram_we)
			vld_q[addr_q] <= 1'b1;
	end

	// shared multiplier: low 24 bits of x first, then the signed upper part
	assign mul_a = {1'b0, g_q};
	assign mul_b = (ph_q == 2'd0) ? {1'b0, x_q[LO_W-1:0]} : x_q[X_W-1:LO_W];
	assign mul_p = mul_a * mul_b;

	assign tdiff = 33'(tref_q) - 33'(tmeas_q);

	// final clamp of the voltage sum
	always_comb begin
		lim     = {33'b0, vlim_q};
		v_clamp = vsum_q;
		v_flag  = 1'b0;
		if (vsum_q > lim) begin
			v_clamp = lim;
			v_flag  = 1'b1;
		end else if (vsum_q < -lim) begin
			v_clamp = -lim;
			v_flag  = 1'b1;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			op_q <= OP_INT;
			ph_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_OPEN: st_q <= ST_FIN;
							MODE_TORQUE: begin
								op_q <= OP_TQ;
								st_q <= ST_SETUP;
							end
							MODE_IMPED: begin
								op_q <= OP_STF;
								st_q <= ST_SETUP;
							end
							default: begin
								op_q <= OP_INT;
								st_q <= ST_SETUP;
							end
						endcase
					end
				end
				ST_SETUP: begin
					ph_q <= '0;
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == PH_LAST)
						st_q <= ST_POST;
				end
				ST_POST: begin
					case (op_q)
						OP_INT: begin
							op_q <= OP_KP;
							st_q <= ST_SETUP;
						end
						OP_KP: begin
							op_q <= OP_KD;
							st_q <= ST_SETUP;
						end
						OP_KD: begin
							op_q <= OP_KI;
							st_q <= ST_SETUP;
						end
						OP_STF: begin
							op_q <= OP_DMP;
							st_q <= ST_SETUP;
						end
						OP_DMP: begin
							op_q <= OP_TQ;
							st_q <= ST_SETUP;
						end
						default: st_q <= ST_FIN;
					endcase
				end
				ST_FIN: begin
					if (out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// item capture and arithmetic datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					joint_q    <= joint_index;
					addr_q     <= AW'(joint_index);
					in_range_q <= (int'(joint_index) < NUM_JOINTS);
					err_q      <= 33'(position_ref) - 33'(position);
					vel_q      <= velocity;
					tref_q     <= torque_ref;
					tmeas_q    <= torque_measured;
					ts_q       <= time_step;
					integ_q    <= '0;
					vsum_q     <= 64'(direct_voltage);
				end
			end
			ST_SETUP: begin
				case (op_q)
					OP_INT: begin
						g_q <= {1'b0, ts_q};
						x_q <= 49'(err_q);
					end
					OP_KP: begin
						g_q <= kp_pos_q;
						x_q <= 49'(err_q);
					end
					OP_KD: begin
						g_q <= kd_pos_q;
						x_q <= 49'(vel_q);
					end
					OP_KI: begin
						g_q <= ki_pos_q;
						x_q <= 49'(integ_q);
					end
					OP_STF: begin
						g_q <= stiff_q;
						x_q <= 49'(err_q);
					end
					OP_DMP: begin
						g_q <= damp_q;
						x_q <= 49'(vel_q);
					end
					default: begin
						g_q <= kp_tq_q;
						x_q <= 49'(tdiff);
					end
				endcase
			end
			ST_MUL: begin
				case (ph_q)
					2'd0: prod_q <= mul_p;
					2'd1: begin
						acc_q  <= ACC_W'(prod_q);
						prod_q <= mul_p;
					end
					2'd2: acc_q <= acc_q + (ACC_W'(prod_q) <<< LO_W);
					default: term_q <= sat_term(acc_q);
				endcase
			end
			ST_POST: begin
				case (op_q)
					OP_INT: begin
						if (in_range_q)
							integ_q <= integ_next;
					end
					OP_KP:  vsum_q <= SUM_W'(term_q);
					OP_KD:  vsum_q <= vsum_q - SUM_W'(term_q);
					OP_KI:  vsum_q <= vsum_q + SUM_W'(term_q);
					OP_STF: vsum_q <= SUM_W'(term_q);
					OP_DMP: tref_q <= sat32(vsum_q - SUM_W'(term_q));
					default: vsum_q <= SUM_W'(term_q);
				endcase
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (st_q == ST_FIN && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_FIN && out_free) begin
			joint_out_q <= joint_q;
			voltage_q   <= v_clamp[31:0];
			clamped_q   <= v_flag;
			tref_out_q  <= tref_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign joint_out       = joint_out_q;
	assign voltage         = voltage_q;
	assign clamped         = clamped_q;
	assign torque_ref_used = tref_out_q;

	// an accepted word always starts work on the next cycle
	`MMJC_ASSERT(a_accept_busy, accept |=> (st_q != ST_IDLE), "accept did not start work")
	// the last multiply pass hands over to the combine step
	`MMJC_ASSERT(a_mul_post, (st_q == ST_MUL && ph_q == PH_LAST) |=> (st_q == ST_POST), "multiply sequence broken")
	// a finished item reaches the output register once it is free
	`MMJC_ASSERT(a_fin_out, (st_q == ST_FIN && !out_valid_q) |=> out_valid_q, "result not presented")

endmodule

// ===== verif/multi_mode_joint_controller_unit_tb.sv =====
// Self-checking testbench: directed table, then random joint samples checked by a bit-true model.
module multi_mode_joint_controller_unit_tb
	import mmjc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_JOINTS  = 32;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_HOLD  = 40;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 190;

	localparam logic signed [63:0] TERM_CAP = 64'sh1000_0000_0000_0000;
	localparam logic signed [63:0] INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] INTEG_LO = -64'sh0000_8000_0000_0000;
	localparam logic signed [63:0] SAT32_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT32_LO = -64'sd2147483648;
	localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;
	localparam logic [30:0]        DT_MAX   = 31'h7FFF_FFFF;
	localparam logic [31:0]        GAIN_MAX = 32'hFFFF_FFFF;

	// position control and the unused codes that fall back to it
	localparam logic [2:0] MODE_POS   = 3'd0;
	localparam logic [2:0] MODE_SPARE4 = 3'd4;
	localparam logic [2:0] MODE_SPARE5 = 3'd5;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	typedef struct packed {
		logic [4:0]         joint;
		logic [2:0]         mode;
		logic signed [31:0] pos_ref;
		logic signed [31:0] pos_meas;
		logic signed [31:0] vel;
		logic signed [31:0] tq_ref;
		logic signed [31:0] tq_meas;
		logic [30:0]        dt;
		logic signed [31:0] v_direct;
	} sample_t;

	typedef struct packed {
		logic [4:0]         joint;
		logic signed [31:0] volts;
		logic               clamp;
		logic signed [31:0] tq_ref;
	} drive_word_t;

	typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  reg_idx;
		logic [31:0] reg_data;
		sample_t     smp;
		logic        typed;
		drive_word_t want;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [4:0]         joint_index = '0;
	logic [2:0]         mode = MODE_POS;
	logic signed [31:0] position_ref = '0;
	logic signed [31:0] position = '0;
	logic signed [31:0] velocity = '0;
	logic signed [31:0] torque_ref = '0;
	logic signed [31:0] torque_measured = '0;
	logic [30:0]        time_step = '0;
	logic signed [31:0] direct_voltage = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [4:0]         joint_out;
	logic signed [31:0] voltage;
	logic               clamped;
	logic signed [31:0] torque_ref_used;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = REG_KP_POS;
	logic [31:0]        cfg_data = '0;

	multi_mode_joint_controller_unit #(
		.NUM_JOINTS(NUM_JOINTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.joint_index(joint_index),
		.mode(mode),
		.position_ref(position_ref),
		.position(position),
		.velocity(velocity),
		.torque_ref(torque_ref),
		.torque_measured(torque_measured),
		.time_step(time_step),
		.direct_voltage(direct_voltage),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.joint_out(joint_out),
		.voltage(voltage),
		.clamped(clamped),
		.torque_ref_used(torque_ref_used),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// model copy of the gain registers and the per-joint integrators
	logic [31:0]        g_kp_pos;
	logic [31:0]        g_kd_pos;
	logic [31:0]        g_ki_pos;
	logic [31:0]        g_kp_tq;
	logic [31:0]        g_stiff;
	logic [31:0]        g_damp;
	logic [30:0]        g_vlim;
	logic signed [47:0] integ_store [NUM_JOINTS];

	drive_word_t drive_due[$];
	plan_row_t   opening_plan[$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor(g * x / 2^16), limited to +/- 2^60
	function automatic logic signed [63:0] gain_term(input logic [31:0] g,
			input logic signed [48:0] x);
		logic signed [81:0] prod;
		prod = $signed({50'd0, g}) * 82'(x);
		prod = prod >>> 16;
		if (prod > 82'(TERM_CAP))
			return TERM_CAP;
		if (prod < -82'(TERM_CAP))
			return -TERM_CAP;
		return prod[63:0];
	endfunction

	// expected drive word for one sample; updates the integrator of its joint
	function automatic drive_word_t predict_drive(input sample_t s);
		drive_word_t        w;
		logic signed [48:0] err;
		logic signed [48:0] diff;
		logic signed [63:0] acc;
		logic signed [63:0] run;
		logic signed [63:0] tref;
		logic signed [63:0] lim;
		err  = 49'($signed(s.pos_ref)) - 49'($signed(s.pos_meas));
		tref = 64'($signed(s.tq_ref));
		lim  = {33'd0, g_vlim};
		run  = '0;
		case (s.mode)
			MODE_OPEN: acc = 64'($signed(s.v_direct));
			MODE_TORQUE, MODE_IMPED: begin
				// impedance builds its own torque reference, saturated to 32 bits
				if (s.mode == MODE_IMPED) begin
					acc = gain_term(g_stiff, err) - gain_term(g_damp, 49'($signed(s.vel)));
					if (acc > SAT32_HI)
						tref = SAT32_HI;
					else if (acc < SAT32_LO)
						tref = SAT32_LO;
					else
						tref = acc;
				end
				diff = 49'(tref - 64'($signed(s.tq_meas)));
				acc  = gain_term(g_kp_tq, diff);
			end
			default: begin
				if (int'(s.joint) < NUM_JOINTS) begin
					run = 64'(integ_store[s.joint]) + gain_term({1'b0, s.dt}, err);
					if (run > INTEG_HI)
						run = INTEG_HI;
					else if (run < INTEG_LO)
						run = INTEG_LO;
					integ_store[s.joint] = run[47:0];
				end
				acc = gain_term(g_kp_pos, err) - gain_term(g_kd_pos, 49'($signed(s.vel)))
					+ gain_term(g_ki_pos, run[48:0]);
			end
		endcase
		w.clamp = 1'b0;
		if (acc > lim) begin
			acc = lim;
			w.clamp = 1'b1;
		end else if (acc < -lim) begin
			acc = -lim;
			w.clamp = 1'b1;
		end
		w.joint  = s.joint;
		w.volts  = acc[31:0];
		w.tq_ref = tref[31:0];
		return w;
	endfunction

	function automatic sample_t mk_sample(input logic [4:0] j, input logic [2:0] m,
			input logic signed [31:0] pref, input logic signed [31:0] pmeas,
			input logic signed [31:0] vel, input logic signed [31:0] tref,
			input logic signed [31:0] tmeas, input logic [30:0] dt,
			input logic signed [31:0] vdir);
		sample_t s;
		s.joint    = j;
		s.mode     = m;
		s.pos_ref  = pref;
		s.pos_meas = pmeas;
		s.vel      = vel;
		s.tq_ref   = tref;
		s.tq_meas  = tmeas;
		s.dt       = dt;
		s.v_direct = vdir;
		return s;
	endfunction

	function automatic drive_word_t mk_word(input logic [4:0] j, input logic signed [31:0] v,
			input logic c, input logic signed [31:0] tref);
		drive_word_t w;
		w.joint  = j;
		w.volts  = v;
		w.clamp  = c;
		w.tq_ref = tref;
		return w;
	endfunction

	function automatic void plan_reg(input logic [2:0] idx, input logic [31:0] data);
		plan_row_t r;
		r = '0;
		r.kind     = ROW_REG;
		r.reg_idx  = idx;
		r.reg_data = data;
		opening_plan.push_back(r);
	endfunction

	function automatic void plan_sample(input sample_t s);
		plan_row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.smp  = s;
		opening_plan.push_back(r);
	endfunction

	function automatic void plan_known(input sample_t s, input drive_word_t w);
		plan_row_t r;
		r = '0;
		r.kind  = ROW_SAMPLE;
		r.smp   = s;
		r.typed = 1'b1;
		r.want  = w;
		opening_plan.push_back(r);
	endfunction

	// directed words: extremes, every mode, clamp edges, saturation paths
	function automatic void build_plan();
		logic signed [31:0] vl;
		vl = $signed({1'b0, VLIM_RESET});
		// reset gains: only open loop gives a nonzero voltage
		plan_known(mk_sample(5'd0, MODE_POS, '0, '0, '0, '0, '0, '0, '0),
			mk_word(5'd0, '0, 1'b0, '0));
		plan_known(mk_sample(5'd31, MODE_OPEN, '0, '0, '0, S32_MIN, '0, '0, S32_MAX),
			mk_word(5'd31, vl, 1'b1, S32_MIN));
		plan_known(mk_sample(5'd1, MODE_OPEN, '0, '0, '0, '0, '0, '0, S32_MIN),
			mk_word(5'd1, -vl, 1'b1, '0));
		plan_known(mk_sample(5'd1, MODE_OPEN, '0, '0, '0, '0, '0, '0, vl),
			mk_word(5'd1, vl, 1'b0, '0));
		plan_known(mk_sample(5'd1, MODE_OPEN, '0, '0, '0, '0, '0, '0, -vl),
			mk_word(5'd1, -vl, 1'b0, '0));
		plan_known(mk_sample(5'd1, MODE_OPEN, '0, '0, '0, '0, '0, '0, vl + 32'sd1),
			mk_word(5'd1, vl, 1'b1, '0));
		plan_known(mk_sample(5'd2, MODE_TORQUE, '0, '0, '0, S32_MAX, S32_MIN, '0, '0),
			mk_word(5'd2, '0, 1'b0, S32_MAX));
		plan_known(mk_sample(5'd3, MODE_IMPED, S32_MAX, S32_MIN, S32_MIN, S32_MAX, '0, '0, '0),
			mk_word(5'd3, '0, 1'b0, '0));
		// unknown codes run the position law and still load the integrator
		plan_known(mk_sample(5'd5, MODE_SPARE4, S32_MAX, S32_MIN, S32_MIN, 32'sh1234, -32'sd1,
			DT_MAX, S32_MAX), mk_word(5'd5, '0, 1'b0, 32'sh1234));
		plan_known(mk_sample(5'd5, MODE_SPARE7, S32_MAX, S32_MIN, S32_MIN, 32'sh1234, -32'sd1,
			DT_MAX, S32_MAX), mk_word(5'd5, '0, 1'b0, 32'sh1234));
		plan_known(mk_sample(5'd4, MODE_SPARE5, S32_MIN, S32_MAX, S32_MAX, S32_MIN, '0,
			DT_MAX, '0), mk_word(5'd4, '0, 1'b0, S32_MIN));
		plan_known(mk_sample(5'd6, MODE_SPARE6, '0, '0, '0, '0, '0, '0, S32_MIN),
			mk_word(5'd6, '0, 1'b0, '0));
		// full-scale torque path; limit with bit 31 set lands on 2^31-1
		plan_reg(REG_KP_TQ, GAIN_MAX);
		plan_reg(REG_STIFF, GAIN_MAX);
		plan_reg(REG_DAMP, GAIN_MAX);
		plan_reg(REG_VLIM, GAIN_MAX);
		plan_known(mk_sample(5'd7, MODE_IMPED, S32_MAX, S32_MIN, '0, '0, S32_MIN, '0, '0),
			mk_word(5'd7, S32_MAX, 1'b1, S32_MAX));
		plan_known(mk_sample(5'd8, MODE_IMPED, S32_MIN, S32_MAX, '0, '0, S32_MAX, '0, '0),
			mk_word(5'd8, -S32_MAX, 1'b1, S32_MIN));
		plan_sample(mk_sample(5'd9, MODE_TORQUE, '0, '0, '0, '0, 32'sd1, '0, '0));
		plan_sample(mk_sample(5'd9, MODE_IMPED, 32'sh10000, '0, 32'sh8000, '0, '0, '0, '0));
		// position gains at full scale: integral term hits the term cap
		plan_reg(REG_KP_POS, GAIN_MAX);
		plan_reg(REG_KD_POS, GAIN_MAX);
		plan_reg(REG_KI_POS, GAIN_MAX);
		plan_sample(mk_sample(5'd5, MODE_POS, S32_MAX, S32_MIN, S32_MIN, '0, '0, DT_MAX, '0));
		plan_sample(mk_sample(5'd5, MODE_POS, S32_MIN, S32_MAX, S32_MAX, '0, '0, DT_MAX, '0));
		plan_sample(mk_sample(5'd4, MODE_POS, '0, '0, S32_MAX, '0, '0, 31'd1, '0));
		// zero limit: any nonzero drive is flagged
		plan_reg(REG_VLIM, '0);
		plan_known(mk_sample(5'd10, MODE_OPEN, '0, '0, '0, '0, '0, '0, 32'sd1),
			mk_word(5'd10, '0, 1'b1, '0));
		plan_known(mk_sample(5'd10, MODE_OPEN, '0, '0, '0, '0, '0, '0, '0),
			mk_word(5'd10, '0, 1'b0, '0));
		plan_known(mk_sample(5'd12, MODE_TORQUE, '0, '0, '0, S32_MIN, S32_MIN, '0, '0),
			mk_word(5'd12, '0, 1'b0, S32_MIN));
		plan_sample(mk_sample(5'd11, MODE_POS, 32'sh100, '0, '0, '0, '0, 31'd65536, '0));
	endfunction

	function automatic logic signed [31:0] rand_signal();
		case ($urandom_range(0, 9))
			0: return S32_MAX;
			1: return S32_MIN;
			2: return '0;
			3, 4, 5, 6: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic logic [30:0] rand_dt();
		case ($urandom_range(0, 7))
			0: return DT_MAX;
			1: return '0;
			2: return 31'($urandom);
			default: return 31'($urandom_range(0, 4096));
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return GAIN_MAX;
			2, 3: return $urandom_range(0, 32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return GAIN_MAX;
			2: return $urandom;
			default: return $urandom_range(32'h0001_0000, 32'h0100_0000);
		endcase
	endfunction

	// mostly a few busy joints, measured position near the reference half the time
	function automatic sample_t rand_sample();
		sample_t s;
		s.joint    = $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
		s.mode     = 3'($urandom_range(0, 7));
		s.pos_ref  = rand_signal();
		s.pos_meas = $urandom_range(0, 1) ? rand_signal()
			: s.pos_ref - ($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
		s.vel      = rand_signal();
		s.tq_ref   = rand_signal();
		s.tq_meas  = rand_signal();
		s.dt       = rand_dt();
		s.v_direct = rand_signal();
		return s;
	endfunction

	// hold off new words until every pending result is back
	task automatic settle();
		in_valid <= 1'b0;
		while (drive_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_HOLD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_KP_POS: g_kp_pos = data;
			REG_KD_POS: g_kd_pos = data;
			REG_KI_POS: g_ki_pos = data;
			REG_KP_TQ:  g_kp_tq = data;
			REG_STIFF:  g_stiff = data;
			REG_DAMP:   g_damp = data;
			REG_VLIM:   g_vlim = data[30:0];
			default: ;
		endcase
	endtask

	task automatic send_sample(input sample_t s, input logic typed, input drive_word_t want);
		drive_word_t w;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		in_valid        <= 1'b1;
		joint_index     <= s.joint;
		mode            <= s.mode;
		position_ref    <= s.pos_ref;
		position        <= s.pos_meas;
		velocity        <= s.vel;
		torque_ref      <= s.tq_ref;
		torque_measured <= s.tq_meas;
		time_step       <= s.dt;
		direct_voltage  <= s.v_direct;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		w = predict_drive(s);
		drive_due.push_back(typed ? want : w);
		// sender gap burst
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// per-phase register set: small, mixed, zero and full-scale settings
	task automatic set_phase(input int ph);
		logic [31:0] g [6];
		logic [31:0] lim;
		settle();
		calm = (ph == 2 || ph == PHASES - 1);
		for (int k = 0; k < 6; k++) begin
			case (ph)
				3: g[k] = GAIN_MAX;
				4: g[k] = '0;
				1, 5: g[k] = rand_gain();
				default: g[k] = $urandom_range(0, 32'h0004_0000);
			endcase
		end
		case (ph)
			3: lim = GAIN_MAX;
			4: lim = 32'h7FFF_FFFF;
			6: lim = '0;
			1, 5: lim = rand_limit();
			default: lim = $urandom_range(32'h0001_0000, 32'h0100_0000);
		endcase
		write_reg(REG_KP_POS, g[0]);
		write_reg(REG_KD_POS, g[1]);
		write_reg(REG_KI_POS, g[2]);
		write_reg(REG_KP_TQ, g[3]);
		write_reg(REG_STIFF, g[4]);
		write_reg(REG_DAMP, g[5]);
		write_reg(REG_VLIM, lim);
	endtask

	// receiver stall bursts
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result check against the oldest pending word
	always @(posedge clk) begin
		drive_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_due.size() == 0) begin
				$error("result for joint %0d with no word pending", joint_out);
				mismatches++;
			end else begin
				w = drive_due.pop_front();
				if (joint_out !== w.joint) begin
					$error("joint_out: expected %0d, got %0d", w.joint, joint_out);
					mismatches++;
				end
				if (voltage !== w.volts) begin
					$error("voltage: expected %0d, got %0d", $signed(w.volts), voltage);
					mismatches++;
				end
				if (clamped !== w.clamp) begin
					$error("clamped: expected %0b, got %0b", w.clamp, clamped);
					mismatches++;
				end
				if (torque_ref_used !== w.tq_ref) begin
					$error("torque_ref_used: expected %0d, got %0d", $signed(w.tq_ref),
						torque_ref_used);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("multi_mode_joint_controller_unit test failed");
			$finish;
		end
	end

	initial begin
		plan_row_t r;
		g_kp_pos = '0;
		g_kd_pos = '0;
		g_ki_pos = '0;
		g_kp_tq  = '0;
		g_stiff  = '0;
		g_damp   = '0;
		g_vlim   = VLIM_RESET;
		for (int k = 0; k < NUM_JOINTS; k++)
			integ_store[k] = '0;
		build_plan();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed table
		foreach (opening_plan[i]) begin
			r = opening_plan[i];
			if (r.kind == ROW_REG) begin
				if (!cfg_valid)
					settle();
				write_reg(r.reg_idx, r.reg_data);
			end else begin
				send_sample(r.smp, r.typed, r.want);
			end
		end
		// random phases, phase 2 and the last one without idling
		for (int ph = 0; ph < PHASES; ph++) begin
			set_phase(ph);
			repeat (PHASE_WORDS) send_sample(rand_sample(), 1'b0, '0);
		end
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (drive_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_HOLD) @(posedge clk);
		if (mismatches == 0 && drive_due.size() == 0)
			$display("multi_mode_joint_controller_unit test passed");
		else
			$display("multi_mode_joint_controller_unit test failed");
		$finish;
	end

endmodule
